### src/column_median_by_sorting_core_assert.svh
// Assertion macros shared by the checker.
`ifndef COLUMN_MEDIAN_BY_SORTING_CORE_ASSERT_SVH
`define COLUMN_MEDIAN_BY_SORTING_CORE_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define CMS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define CMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

### src/cms_pkg.sv
package cms_pkg;
	localparam int unsigned MAX_ROWS_DEF = 256;
	localparam int unsigned COLUMNS_DEF = 3;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned CNT_W = 9;
	localparam logic [CNT_W-1:0] SAMPLE_COUNT_RESET = 9'd201;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_row;   // capture the incoming row
		logic cmp_rd;     // present read address for the shift step
		logic shift_wr;   // write shifted word or new value
		logic med_rd;     // present median read address
		logic med_cap_lo; // capture lower middle element
		logic med_cap_hi; // capture upper middle element
		logic med_done;   // result shown; clears medians if count is zero
	} cms_cmd_t;

	typedef struct packed {
		logic stop;       // insertion point found for the current column
	} cms_stat_t;
endpackage

### src/column_median_by_sorting_core.sv
// An accepted row is inserted column by column into the shared RAM by read
// (S_RD) and shift (S_SHIFT) steps down to its place; a row met by a full
// store is dropped. A last row then reads each column's middle entries (S_MRD,
// S_MLO, S_MHI) and presents the result. Rows are taken one at a time.
// Reset: asynchronous, clears the row count, overflow flag and sample_count
// to 201; store contents stay undefined and are never read before written.
module column_median_by_sorting_core #(
	parameter int unsigned MAX_ROWS = cms_pkg::MAX_ROWS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [31:0]         value_a,
	input  logic signed [31:0]         value_b,
	input  logic signed [31:0]         value_c,
	input  logic                       last_row,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [31:0]         median_a,
	output logic signed [31:0]         median_b,
	output logic signed [31:0]         median_c,
	output logic                       count_error,
	output logic [cms_pkg::CNT_W-1:0]  rows_seen,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [cms_pkg::CNT_W-1:0]  cfg_data
);
	import cms_pkg::*;
	localparam int unsigned PW = $clog2(MAX_ROWS + 1);
	localparam int unsigned KW = $clog2(COLUMNS_DEF + 1);

	cms_cmd_t                  cmd;
	cms_stat_t                 stat;
	logic [KW-1:0]             col;
	logic [PW-1:0]             pos, count;
	logic [CNT_W-1:0]          sample_count_q;
	logic [3*DATA_W-1:0]       row_in, medians;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= SAMPLE_COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			sample_count_q <= cfg_data;
		end
	end

	assign row_in = {value_c, value_b, value_a};

	cms_ctrl #(.MAX_ROWS(MAX_ROWS), .COLUMNS(COLUMNS_DEF)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_last(last_row),
		.in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall),
		.sample_count(sample_count_q), .stat(stat), .cmd(cmd), .col(col),
		.pos(pos), .count(count), .count_error(count_error), .rows_seen(rows_seen)
	);

	cms_datapath #(.MAX_ROWS(MAX_ROWS), .COLUMNS(COLUMNS_DEF)) u_dp (
		.clk(clk), .cmd(cmd), .col(col), .pos(pos), .count(count),
		.row_in(row_in), .stat(stat), .medians(medians)
	);

	assign median_a = medians[0 +: DATA_W];
	assign median_b = medians[DATA_W +: DATA_W];
	assign median_c = medians[2*DATA_W +: DATA_W];
endmodule

### src/cms_ram.sv
module cms_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

### src/cms_datapath.sv
module cms_datapath #(
	parameter int unsigned MAX_ROWS = cms_pkg::MAX_ROWS_DEF,
	parameter int unsigned COLUMNS = cms_pkg::COLUMNS_DEF
) (
	input  logic                                clk,
	input  cms_pkg::cms_cmd_t                   cmd,
	input  logic [$clog2(COLUMNS+1)-1:0]        col,
	input  logic [$clog2(MAX_ROWS+1)-1:0]       pos,
	input  logic [$clog2(MAX_ROWS+1)-1:0]       count,
	input  logic [COLUMNS*cms_pkg::DATA_W-1:0]  row_in,
	output cms_pkg::cms_stat_t                  stat,
	output logic [COLUMNS*cms_pkg::DATA_W-1:0]  medians
);
	import cms_pkg::*;
	localparam int unsigned AW = $clog2(MAX_ROWS);
	localparam int unsigned CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int unsigned PW = $clog2(MAX_ROWS + 1);
	localparam int unsigned RAW = $clog2(COLUMNS * MAX_ROWS);

	logic [COLUMNS*DATA_W-1:0] row_q;
	logic [COLUMNS*DATA_W-1:0] med_q;
	logic signed [DATA_W-1:0]  lo_q;
	logic signed [DATA_W-1:0]  new_v;
	logic signed [DATA_W-1:0]  rdata;
	logic                      we;
	logic [RAW-1:0]            waddr, raddr;
	logic [DATA_W-1:0]         wdata;
	logic [PW-1:0]             rd_pos;
	logic [CW-1:0]             col_i;
	logic signed [DATA_W:0]    sum;

	assign col_i = col[CW-1:0];
	assign new_v = row_q[col_i*DATA_W +: DATA_W];

	// Reads: the shift step reads entry pos-1, the median step reads pos.
	always_comb begin
		rd_pos = cmd.cmp_rd ? (pos - PW'(1)) : pos;
	end
	assign raddr = RAW'(col_i * MAX_ROWS + rd_pos[AW-1:0]);

	// A shift writes the read word up one place; a stop writes the new value.
	assign stat.stop = (pos == '0) || !(rdata > new_v);
	assign we = cmd.shift_wr;
	assign wdata = stat.stop ? new_v : rdata;
	assign waddr = RAW'(col_i * MAX_ROWS + pos[AW-1:0]);

	cms_ram #(.WIDTH(DATA_W), .DEPTH(COLUMNS * MAX_ROWS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	assign sum = {lo_q[DATA_W-1], lo_q} + {rdata[DATA_W-1], rdata};

	always_ff @(posedge clk) begin
		if (cmd.load_row) begin
			row_q <= row_in;
		end
		if (cmd.med_cap_lo) begin
			lo_q <= rdata;
		end
		if (cmd.med_cap_hi) begin
			if (count[0]) begin
				med_q[col_i*DATA_W +: DATA_W] <= rdata;
			end else begin
				med_q[col_i*DATA_W +: DATA_W] <= sum[DATA_W:1];
			end
		end
		if (cmd.med_done && count == '0) begin
			med_q <= '0;
		end
	end
	assign medians = med_q;
endmodule

### src/cms_ctrl.sv
module cms_ctrl #(
	parameter int unsigned MAX_ROWS = cms_pkg::MAX_ROWS_DEF,
	parameter int unsigned COLUMNS = cms_pkg::COLUMNS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_last,
	output logic                          in_stall,
	output logic                          out_valid,
	input  logic                          out_stall,
	input  logic [cms_pkg::CNT_W-1:0]     sample_count,
	input  cms_pkg::cms_stat_t            stat,
	output cms_pkg::cms_cmd_t             cmd,
	output logic [$clog2(COLUMNS+1)-1:0]  col,
	output logic [$clog2(MAX_ROWS+1)-1:0] pos,
	output logic [$clog2(MAX_ROWS+1)-1:0] count,
	output logic                          count_error,
	output logic [cms_pkg::CNT_W-1:0]     rows_seen
);
	import cms_pkg::*;
	localparam int unsigned PW = $clog2(MAX_ROWS + 1);
	localparam int unsigned KW = $clog2(COLUMNS + 1);

	typedef enum logic [2:0] {
		S_IDLE, S_RD, S_SHIFT, S_MRD, S_MLO, S_MHI, S_OUT
	} state_t;

	state_t          state_q;
	logic [PW-1:0]   cnt_q, pos_q;
	logic [KW-1:0]   col_q;
	logic            last_q, ovf_q, err_q;
	logic [CNT_W-1:0] seen_q;
	logic            accept;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign col = col_q;
	assign pos = pos_q;
	assign count = cnt_q;
	assign count_error = err_q;
	assign rows_seen = seen_q;

	always_comb begin
		cmd = '0;
		cmd.load_row = accept;
		cmd.cmp_rd = (state_q == S_RD);
		cmd.shift_wr = (state_q == S_SHIFT);
		cmd.med_rd = (state_q == S_MRD);
		cmd.med_cap_lo = (state_q == S_MLO);
		cmd.med_cap_hi = (state_q == S_MHI);
		cmd.med_done = (state_q == S_OUT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			pos_q <= '0;
			col_q <= '0;
			last_q <= 1'b0;
			ovf_q <= 1'b0;
			err_q <= 1'b0;
			seen_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						last_q <= in_last;
						col_q <= '0;
						pos_q <= cnt_q;
						if (cnt_q == PW'(MAX_ROWS)) begin
							ovf_q <= 1'b1;
							state_q <= in_last ? S_MRD : S_IDLE;
							pos_q <= (cnt_q >> 1) - PW'(1);
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					state_q <= S_SHIFT;
				end
				S_SHIFT: begin
					// The stored word at pos-1 moves up unless it is not above
					// the new value, which then lands at pos.
					if (stat.stop) begin
						if (col_q == KW'(COLUMNS - 1)) begin
							col_q <= '0;
							if (last_q) begin
								state_q <= S_MRD;
								pos_q <= ((cnt_q + PW'(1)) >> 1) - PW'(1);
							end else begin
								state_q <= S_IDLE;
							end
							cnt_q <= cnt_q + PW'(1);
						end else begin
							col_q <= col_q + KW'(1);
							pos_q <= cnt_q;
							state_q <= S_RD;
						end
					end else begin
						pos_q <= pos_q - PW'(1);
						state_q <= S_RD;
					end
				end
				S_MRD: begin
					// pos holds n/2-1 for even n; odd n needs only n/2.
					if (cnt_q[0]) begin
						pos_q <= cnt_q >> 1;
						state_q <= S_MLO;
					end else begin
						pos_q <= cnt_q >> 1;
						state_q <= S_MLO;
					end
				end
				S_MLO: begin
					state_q <= S_MHI;
				end
				S_MHI: begin
					if (col_q == KW'(COLUMNS - 1)) begin
						state_q <= S_OUT;
						seen_q <= CNT_W'(cnt_q);
						err_q <= ovf_q || (CNT_W'(cnt_q) != sample_count);
					end else begin
						col_q <= col_q + KW'(1);
						pos_q <= (cnt_q >> 1) - PW'(1);
						state_q <= S_MRD;
					end
				end
				S_OUT: begin
					if (!out_stall) begin
						state_q <= S_IDLE;
						cnt_q <= '0;
						ovf_q <= 1'b0;
						col_q <= '0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### src/cms_checker.sv
`include "column_median_by_sorting_core_assert.svh"
module cms_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic [cms_pkg::CNT_W-1:0] rows_seen
);
	`CMS_ASSERT_IMP(a_busy_out, clk, arst_n, out_valid, in_stall, "row taken during result")
	`CMS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(rows_seen), "result dropped")
	`CMS_ASSERT_IMP(a_rows_nz, clk, arst_n, out_valid, rows_seen != '0, "empty result")
endmodule

bind column_median_by_sorting_core cms_checker u_cms_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .rows_seen(rows_seen)
);

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
	import cms_pkg::*;

	localparam int unsigned NCOL = COLUMNS_DEF;
	localparam int unsigned CAP = MAX_ROWS_DEF;
	localparam longint unsigned CYCLE_LIMIT = 3000000;

	typedef struct packed {
		logic signed [DATA_W-1:0] a;
		logic signed [DATA_W-1:0] b;
		logic signed [DATA_W-1:0] c;
		logic last;
	} row_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] a;
		logic signed [DATA_W-1:0] b;
		logic signed [DATA_W-1:0] c;
		logic err;
		logic [CNT_W-1:0] seen;
	} median_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [31:0] value_a, value_b, value_c;
	logic last_row;
	logic out_valid;
	logic out_stall;
	logic signed [31:0] median_a, median_b, median_c;
	logic count_error;
	logic [CNT_W-1:0] rows_seen;
	logic cfg_valid;
	logic cfg_ready;
	logic [CNT_W-1:0] cfg_data;

	column_median_by_sorting_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.value_a(value_a), .value_b(value_b), .value_c(value_c), .last_row(last_row),
		.out_valid(out_valid), .out_stall(out_stall),
		.median_a(median_a), .median_b(median_b), .median_c(median_c),
		.count_error(count_error), .rows_seen(rows_seen),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	row_t row_q[$];
	median_t median_q[$];
	logic signed [DATA_W-1:0] sorted_cols[NCOL][$];
	logic [CNT_W-1:0] expected_count;
	logic dropped_row;
	int unsigned send_idle, recv_idle;
	int unsigned fails;
	longint unsigned cycles;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic logic signed [DATA_W-1:0] column_median_of(int col);
		int n;
		logic signed [DATA_W:0] sum;
		n = sorted_cols[col].size();
		if (n == 0)
			return '0;
		if (n % 2 == 1)
			return sorted_cols[col][n/2];
		sum = {sorted_cols[col][n/2-1][DATA_W-1], sorted_cols[col][n/2-1]}
			+ {sorted_cols[col][n/2][DATA_W-1], sorted_cols[col][n/2]};
		// Arithmetic shift gives the floor for negative sums too.
		return sum[DATA_W:1];
	endfunction

	task automatic insert_value(int col, logic signed [DATA_W-1:0] v);
		int p;
		p = sorted_cols[col].size();
		while (p > 0 && sorted_cols[col][p-1] > v)
			p--;
		sorted_cols[col].insert(p, v);
	endtask

	task automatic predict_row(row_t r);
		median_t m;
		int n;
		if (sorted_cols[0].size() < CAP) begin
			insert_value(0, r.a);
			insert_value(1, r.b);
			insert_value(2, r.c);
		end else begin
			dropped_row = 1'b1;
		end
		if (r.last) begin
			n = sorted_cols[0].size();
			m.a = column_median_of(0);
			m.b = column_median_of(1);
			m.c = column_median_of(2);
			m.seen = n[CNT_W-1:0];
			m.err = dropped_row || (m.seen != expected_count);
			median_q.push_back(m);
			for (int k = 0; k < NCOL; k++)
				sorted_cols[k].delete();
			dropped_row = 1'b0;
		end
	endtask

	// Driver: the payload is held while stalled; prediction happens on acceptance.
	always @(posedge clk or negedge arst_n) begin
		row_t r;
		if (!arst_n) begin
			in_valid <= 1'b0;
			value_a <= '0;
			value_b <= '0;
			value_c <= '0;
			last_row <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				predict_row('{value_a, value_b, value_c, last_row});
			if (!in_valid || !in_stall) begin
				if (row_q.size() > 0 && $urandom_range(99) >= send_idle) begin
					r = row_q.pop_front();
					in_valid <= 1'b1;
					value_a <= r.a;
					value_b <= r.b;
					value_c <= r.c;
					last_row <= r.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else
			out_stall <= ($urandom_range(99) < recv_idle);
	end

	// Monitor.
	always @(posedge clk) begin
		median_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (median_q.size() == 0) begin
				$error("result with no expectation waiting");
				fails++;
			end else begin
				e = median_q.pop_front();
				if (median_a !== e.a) begin
					$error("median_a: expected %0d, got %0d", e.a, median_a);
					fails++;
				end
				if (median_b !== e.b) begin
					$error("median_b: expected %0d, got %0d", e.b, median_b);
					fails++;
				end
				if (median_c !== e.c) begin
					$error("median_c: expected %0d, got %0d", e.c, median_c);
					fails++;
				end
				if (count_error !== e.err) begin
					$error("count_error: expected %0d, got %0d", e.err, count_error);
					fails++;
				end
				if (rows_seen !== e.seen) begin
					$error("rows_seen: expected %0d, got %0d", e.seen, rows_seen);
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic wait_drained();
		while (row_q.size() != 0 || in_valid || median_q.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_sample_count(logic [CNT_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		while (!cfg_ready)
			@(negedge clk);
		@(posedge clk);
		expected_count = v;
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [DATA_W-1:0] pick_value(int unsigned mode);
		case (mode)
			0: return $urandom_range(3) - 2;
			1: return 32'h7FFF_FFFF - $urandom_range(2);
			2: return 32'h8000_0000 + $urandom_range(2);
			default: return $urandom();
		endcase
	endfunction

	task automatic push_set(int unsigned n);
		row_t r;
		int unsigned mode;
		mode = $urandom_range(5);
		for (int unsigned i = 0; i < n; i++) begin
			r.a = pick_value(mode);
			r.b = pick_value($urandom_range(5));
			r.c = pick_value(3);
			r.last = (i == n - 1);
			row_q.push_back(r);
		end
	endtask

	task automatic push_row(logic signed [31:0] a, logic signed [31:0] b,
			logic signed [31:0] c, logic last);
		row_q.push_back('{a, b, c, last});
	endtask

	initial begin
		int unsigned n;
		int unsigned pushed;
		fails = 0;
		cycles = 0;
		send_idle = 0;
		recv_idle = 0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		expected_count = SAMPLE_COUNT_RESET;
		dropped_row = 1'b0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: single row, extremes, floor of negative odd sums.
		push_row(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, 1'b1);
		push_row(32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd3, 1'b0);
		push_row(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, 1'b1);
		push_row(32'sh8000_0000, 32'sh8000_0000, -32'sd1, 1'b0);
		push_row(32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd2, 1'b1);
		push_row(32'sd5, -32'sd7, 32'sd1, 1'b0);
		push_row(-32'sd9, 32'sd7, 32'sd1, 1'b0);
		push_row(32'sd0, 32'sd0, 32'sd1, 1'b1);
		push_row(32'sd4, 32'sd4, 32'sd2, 1'b0);
		push_row(32'sd1, 32'sd3, -32'sd2, 1'b0);
		push_row(32'sd3, 32'sd1, 32'sd2, 1'b0);
		push_row(32'sd2, 32'sd2, -32'sd2, 1'b1);
		wait_drained();

		// Store full: one row beyond capacity is dropped, the last one.
		write_sample_count(CNT_W'(CAP));
		push_set(CAP + 1);
		wait_drained();
		write_sample_count(CNT_W'(2));
		push_set(2);
		push_set(3);
		wait_drained();

		// Random part in three idling modes; the sender pauses between segments.
		pushed = 0;
		for (int seg = 0; seg < 6; seg++) begin
			case (seg / 2)
				0: begin send_idle = 20; recv_idle = 78; end
				1: begin send_idle = 78; recv_idle = 20; end
				default: begin send_idle = 0; recv_idle = 0; end
			endcase
			case (seg)
				0: write_sample_count(CNT_W'(0));
				1: write_sample_count(9'h1FF);
				2: write_sample_count(CNT_W'(1));
				default: write_sample_count(CNT_W'($urandom_range(1, 12)));
			endcase
			while (pushed < (seg + 1) * 135) begin
				if ($urandom_range(1) == 1 && expected_count >= 1 && expected_count <= 40)
					n = expected_count;
				else if ($urandom_range(9) == 0)
					n = $urandom_range(13, 40);
				else
					n = $urandom_range(1, 12);
				push_set(n);
				pushed += n;
			end
			wait_drained();
		end

		repeat (50) @(posedge clk);
		if (fails == 0 && median_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
